[hw/rtl/bounded_stack_with_search_macros.svh]
// Assertion macros for the bounded stack with search.
// Taken in by the top level; no other dependencies.
`ifndef BOUNDED_STACK_WITH_SEARCH_MACROS_SVH
`define BOUNDED_STACK_WITH_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define BSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("stack assertion failed");

// Next-cycle implication, disabled while reset is held
`define BSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("stack assertion failed");

`endif

[hw/rtl/bss_pkg.sv]
// Shared types and codes for the bounded stack with search.
// No dependencies.
package bss_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int CAP_W  = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        SEL_IMM,
        SEL_READ,
        SEL_SCAN
    } t_res_sel;

    typedef struct packed {
        logic     in_ready;
        logic     scan_step;
        logic     load_out;
        t_res_sel sel;
    } t_ctl_cmd;

    typedef struct packed {
        logic req_valid;
        logic out_free;
        logic need_read;
        logic need_scan;
        logic hit;
        logic last;
    } t_dp_status;

endpackage

[hw/rtl/bss_req_if.sv]
// Request channel: operation and value, valid/ready handshake.
// Depends on bss_pkg.
interface bss_req_if;
    logic                                valid;
    logic                                ready;
    logic [bss_pkg::OP_W-1:0]            op;
    logic signed [bss_pkg::DATA_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

[hw/rtl/bss_rsp_if.sv]
// Response channel: status, data, match index and count, valid/ready handshake.
// Depends on bss_pkg.
interface bss_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [bss_pkg::ST_W-1:0]            status;
    logic signed [bss_pkg::DATA_W-1:0]   data;
    logic [bss_pkg::IDX_W-1:0]           found_index;
    logic [bss_pkg::CNT_W-1:0]           count;

    modport source (output valid, output status, output data, output found_index,
                    output count, input ready);
    modport sink   (input valid, input status, input data, input found_index,
                    input count, output ready);
endinterface

[hw/rtl/bss_cfg_if.sv]
// Configuration write channel for the capacity register.
// Depends on bss_pkg.
interface bss_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bss_pkg::CAP_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/bounded_stack_with_search.sv]
// Bounded LIFO stack of signed 32-bit values with top-down search.
// Push, clear, unused codes and any operation refused as full or empty load
// their result as they are accepted; pop and peek add a registered read of
// the entry memory; a search examines entries one by one from the top down,
// up to the whole fill. One item is worked on at a time; a result waits in
// an output register and the next item is taken in the cycle that register
// is drained. The entry memory is not cleared after reset.
// Depends on bss_pkg, the channel interfaces, bss_controller and bss_datapath.
`include "bounded_stack_with_search_macros.svh"

module bounded_stack_with_search #(
    parameter int DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bss_req_if.sink      i_req,
    bss_rsp_if.source    o_rsp,
    bss_cfg_if.sink      i_cfg
);

    bss_pkg::t_ctl_cmd   cmd;
    bss_pkg::t_dp_status dp_status;

    bss_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (dp_status),
        .o_cmd    (cmd)
    );

    bss_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (dp_status)
    );

    `BSS_ASSERT_SAME(a_no_accept_while_blocked, i_clk, i_rst_n, i_req.ready && o_rsp.valid, o_rsp.ready)

    `BSS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_req.valid && i_req.ready && (i_req.op == bss_pkg::OP_CLEAR), o_rsp.valid && (o_rsp.count == '0) && (o_rsp.status == bss_pkg::ST_OK))

    `BSS_ASSERT_SAME(a_empty_has_no_data, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status == bss_pkg::ST_EMPTY), (o_rsp.data == '0) && (o_rsp.count == '0))

endmodule

[hw/rtl/bss_datapath.sv]
// Datapath: entry memory, fill count, capacity register, scan pointer and
// output register. Depends on bss_pkg and the three channel interfaces.
module bss_datapath #(
    parameter int DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bss_req_if.sink              i_req,
    bss_rsp_if.source            o_rsp,
    bss_cfg_if.sink              i_cfg,
    input  bss_pkg::t_ctl_cmd    i_cmd,
    output bss_pkg::t_dp_status  o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int LW = (FW > bss_pkg::CAP_W) ? FW : bss_pkg::CAP_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    logic [bss_pkg::DATA_W-1:0]        mem [DEPTH];
    logic [bss_pkg::DATA_W-1:0]        r_rd_data;
    logic [FW-1:0]                     r_fill, n_fill;
    logic [bss_pkg::CAP_W-1:0]         r_capacity;
    logic [bss_pkg::DATA_W-1:0]        r_value;
    logic [AW-1:0]                     r_scan_addr;

    logic                              r_out_valid;
    logic [bss_pkg::ST_W-1:0]          r_out_status;
    logic [bss_pkg::DATA_W-1:0]        r_out_data;
    logic [bss_pkg::IDX_W-1:0]         r_out_index;
    logic [bss_pkg::CNT_W-1:0]         r_out_count;

    logic                              accept;
    logic                              empty;
    logic                              full;
    logic [LW-1:0]                     cap_l;
    logic [LW-1:0]                     limit;
    logic                              is_push, is_pop, is_peek, is_clear, is_search;
    logic                              wr_en, rd_en;
    logic [AW-1:0]                     top_addr;
    logic [AW-1:0]                     rd_addr;
    logic                              hit;
    logic [bss_pkg::ST_W-1:0]          res_status;
    logic [bss_pkg::DATA_W-1:0]        res_data;
    logic [bss_pkg::IDX_W-1:0]         res_index;
    logic [FW-1:0]                     res_fill;

    assign accept    = i_req.valid && i_cmd.in_ready;
    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign is_push   = (i_req.op == bss_pkg::OP_PUSH);
    assign is_pop    = (i_req.op == bss_pkg::OP_POP);
    assign is_peek   = (i_req.op == bss_pkg::OP_PEEK);
    assign is_clear  = (i_req.op == bss_pkg::OP_CLEAR);
    assign is_search = (i_req.op == bss_pkg::OP_SEARCH);

    assign empty = (r_fill == '0);
    assign cap_l = LW'(r_capacity);
    assign limit = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
    assign full  = (LW'(r_fill) >= limit);

    assign top_addr = AW'(r_fill - FW'(1));
    assign rd_addr  = accept ? top_addr : (r_scan_addr - AW'(1));
    assign rd_en    = accept || i_cmd.scan_step;
    assign wr_en    = accept && is_push && !full;
    assign hit      = (r_rd_data == r_value);

    always_comb begin
        n_fill = r_fill;
        if (accept) begin
            if (is_push && !full) begin
                n_fill = r_fill + FW'(1);
            end else if (is_pop && !empty) begin
                n_fill = r_fill - FW'(1);
            end else if (is_clear) begin
                n_fill = '0;
            end
        end
    end

    always_comb begin
        res_status = bss_pkg::ST_OK;
        res_data   = '0;
        res_index  = '0;
        res_fill   = r_fill;
        unique case (i_cmd.sel)
            bss_pkg::SEL_IMM: begin
                res_fill = n_fill;
                if (is_push && full) begin
                    res_status = bss_pkg::ST_FULL;
                end else if ((is_pop || is_peek) && empty) begin
                    res_status = bss_pkg::ST_EMPTY;
                end else if (is_search && empty) begin
                    res_status = bss_pkg::ST_NOTFOUND;
                end
            end
            bss_pkg::SEL_READ: begin
                res_data = r_rd_data;
            end
            bss_pkg::SEL_SCAN: begin
                if (hit) begin
                    res_index = bss_pkg::IDX_W'(r_scan_addr);
                end else begin
                    res_status = bss_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                res_status = bss_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(r_fill)] <= i_req.value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_capacity  <= bss_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (i_cfg.valid) begin
                r_capacity <= i_cfg.data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value     <= i_req.value;
            r_scan_addr <= top_addr;
        end else if (i_cmd.scan_step) begin
            r_scan_addr <= r_scan_addr - AW'(1);
        end
        if (i_cmd.load_out) begin
            r_out_status <= res_status;
            r_out_data   <= res_data;
            r_out_index  <= res_index;
            r_out_count  <= bss_pkg::CNT_W'(res_fill);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.data        = r_out_data;
    assign o_rsp.found_index = r_out_index;
    assign o_rsp.count       = r_out_count;

    assign o_status.req_valid = i_req.valid;
    assign o_status.out_free  = !r_out_valid || o_rsp.ready;
    assign o_status.need_read = (is_pop || is_peek) && !empty;
    assign o_status.need_scan = is_search && !empty;
    assign o_status.hit       = hit;
    assign o_status.last      = (r_scan_addr == '0);

endmodule

[hw/rtl/bss_controller.sv]
// Controller: sequences accept, memory read, search scan and result load.
// Depends on bss_pkg.
module bss_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bss_pkg::t_dp_status  i_status,
    output bss_pkg::t_ctl_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = (r_state == S_IDLE) && i_status.out_free && i_status.req_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.load_out  = 1'b0;
        o_cmd.sel       = bss_pkg::SEL_IMM;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = i_status.out_free;
                if (accept) begin
                    if (i_status.need_read) begin
                        n_state = S_READ;
                    end else if (i_status.need_scan) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.load_out = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.sel = bss_pkg::SEL_READ;
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.sel = bss_pkg::SEL_SCAN;
                if (i_status.hit || i_status.last) begin
                    if (i_status.out_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
